>>> sv/pta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID tracking controller package
// Shared types, register indexes and widths of the arithmetic units.
// ----------------------------------------------------------------------------
package pta_pkg;

   // Field widths of the stream payloads.
   localparam int DATA_W = 32;
   localparam int STEP_W = 31;
   localparam int WORD_W = 64;

   // Register file indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MAX    = 3'd4;

   // Digit-serial multiplier geometry.
   localparam int MUL_WIDE_W   = 64;
   localparam int MUL_NARROW_W = 32;
   localparam int MUL_DIGIT_W  = 8;
   localparam int MUL_STEPS    = MUL_NARROW_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W    = $clog2(MUL_STEPS);

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_E,
      ST_MUL_I,
      ST_SUM,
      ST_SAT_ADD,
      ST_CLAMP,
      ST_DIFF,
      ST_CHECK,
      ST_DIV,
      ST_MUL_T,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        [STEP_W-1:0] time_step;
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] setpoint_rate;
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] measured_rate;
   } item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic        [STEP_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic signed [DATA_W-1:0] out_min;
      logic signed [DATA_W-1:0] out_max;
   } gains_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] drive;
      logic signed [DATA_W-1:0] integral_term;
      logic                     saturated;
   } result_type;

   typedef struct packed {
      logic                    start;
      logic                    neg;
      logic [MUL_WIDE_W-1:0]   wide;
      logic [MUL_NARROW_W-1:0] narrow;
   } mul_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [WORD_W-1:0] mag;
      logic [STEP_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] value;
   } div_rsp_type;

endpackage

>>> sv/pta_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared fixed-point multiplier
// Multiplies a 64-bit magnitude by a 32-bit magnitude one byte per cycle,
// then applies the sign, drops the fraction bits rounding toward minus
// infinity and saturates to 64-bit signed.
// ----------------------------------------------------------------------------
module pta_mul
   import pta_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   localparam int PROD_W = MUL_WIDE_W + MUL_NARROW_W;
   localparam int PART_W = MUL_WIDE_W + MUL_DIGIT_W;
   localparam logic signed [PROD_W:0] SAT_HI =
      (PROD_W+1)'(64'h7FFF_FFFF_FFFF_FFFF);
   localparam logic signed [PROD_W:0] SAT_LO = -SAT_HI - 1;

   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [MUL_WIDE_W-1:0]   wide_ff, wide_in;
   logic [MUL_NARROW_W-1:0] narrow_ff, narrow_in;
   logic                    neg_ff, neg_in;
   logic [MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic signed [WORD_W-1:0] value_ff, value_in;

   logic [PART_W-1:0]       partial;
   logic                    last_step;
   logic signed [PROD_W:0]  prod_signed;
   logic signed [PROD_W:0]  prod_shift;

   // One byte of the narrow operand per cycle, most significant first.
   always_comb begin
      partial   = PART_W'(wide_ff) *
                  PART_W'(narrow_ff[MUL_NARROW_W-1 -: MUL_DIGIT_W]);
      last_step = (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1));
   end

   // Sign, floor shift and saturation of the finished product.
   always_comb begin
      prod_signed = neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
      prod_shift  = prod_signed >>> FRAC_BITS;
   end

   // Next values of the operand and product registers.
   always_comb begin
      prod_in   = prod_ff;
      wide_in   = wide_ff;
      narrow_in = narrow_ff;
      neg_in    = neg_ff;
      value_in  = value_ff;
      if (cmd.start) begin
         prod_in   = '0;
         wide_in   = cmd.wide;
         narrow_in = cmd.narrow;
         neg_in    = cmd.neg;
      end else if (busy_ff) begin
         prod_in   = (prod_ff << MUL_DIGIT_W) + PROD_W'(partial);
         narrow_in = narrow_ff << MUL_DIGIT_W;
      end
      if (fin_ff) begin
         if (prod_shift > SAT_HI) begin
            value_in = 64'sh7FFF_FFFF_FFFF_FFFF;
         end else if (prod_shift < SAT_LO) begin
            value_in = 64'sh8000_0000_0000_0000;
         end else begin
            value_in = prod_shift[WORD_W-1:0];
         end
      end
   end

   // Step counter and completion flags.
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = busy_ff && last_step;
      done_in = fin_ff;
      if (cmd.start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + MUL_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      wide_ff   <= wide_in;
      narrow_ff <= narrow_in;
      neg_ff    <= neg_in;
      value_ff  <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

>>> sv/pta_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integrator trim divider
// Restoring division of (magnitude << FRAC_BITS) by the integral gain, two
// quotient bits per cycle, truncated toward zero and saturated to the
// integrator range.
// ----------------------------------------------------------------------------
module pta_div
   import pta_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   localparam int DIV_W     = ((WORD_W + FRAC_BITS + 1) / 2) * 2;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_W-1:0] Q_POS_LIM =
      DIV_W'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
   localparam logic [DIV_W-1:0] Q_NEG_LIM = Q_POS_LIM + DIV_W'(1);
   localparam logic signed [WORD_W-1:0] ACC_HI64 =
      WORD_W'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
   localparam logic signed [WORD_W-1:0] ACC_LO64 = -ACC_HI64 - 64'sd1;

   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]    div_ff, div_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic signed [WORD_W-1:0] value_ff, value_in;

   logic [STEP_W:0] trial_a, trial_b, divisor_ext, rest_a, rest_b;
   logic            take_a, take_b;
   logic            last_step;

   // Two dependent restoring steps on the narrow remainder.
   always_comb begin
      divisor_ext = {1'b0, div_ff};
      trial_a     = {rem_ff, num_ff[DIV_W-1]};
      take_a      = (trial_a >= divisor_ext);
      rest_a      = take_a ? trial_a - divisor_ext : trial_a;
      trial_b     = {rest_a[STEP_W-1:0], num_ff[DIV_W-2]};
      take_b      = (trial_b >= divisor_ext);
      rest_b      = take_b ? trial_b - divisor_ext : trial_b;
      last_step   = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   end

   // Next values of the dividend, quotient and remainder.
   always_comb begin
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      value_in = value_ff;
      if (cmd.start) begin
         num_in = DIV_W'({cmd.mag, {FRAC_BITS{1'b0}}});
         quo_in = '0;
         rem_in = '0;
         div_in = cmd.divisor;
         neg_in = cmd.neg;
      end else if (busy_ff) begin
         num_in = num_ff << 2;
         quo_in = {quo_ff[DIV_W-3:0], take_a, take_b};
         rem_in = rest_b[STEP_W-1:0];
      end
      if (fin_ff) begin
         if (neg_ff) begin
            value_in = (quo_ff > Q_NEG_LIM) ? ACC_LO64 : WORD_W'(~quo_ff + DIV_W'(1));
         end else begin
            value_in = (quo_ff > Q_POS_LIM) ? ACC_HI64 : WORD_W'(quo_ff);
         end
      end
   end

   // Step counter and completion flags.
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = busy_ff && last_step;
      done_in = fin_ff;
      if (cmd.start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

>>> sv/pta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step sequencer
// Holds the integrator and the intermediate terms of one step and walks the
// shared multiplier and the trim divider through the control law.
// ----------------------------------------------------------------------------
module pta_ctrl
   import pta_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_accept,
   input  item_type    item,
   input  gains_type   gains,
   output logic        item_ready,
   output result_type  result,
   input  logic        result_take,
   output mul_cmd_type mul_cmd,
   input  mul_rsp_type mul_rsp,
   output div_cmd_type div_cmd,
   input  div_rsp_type div_rsp
);

   localparam logic [STEP_W-1:0] ONE_Q = STEP_W'(64'd1 << FRAC_BITS);
   localparam logic signed [WORD_W:0] ACC_HI65 =
      (WORD_W+1)'((66'd1 << (ACC_WIDTH - 1)) - 66'd1);
   localparam logic signed [WORD_W:0] ACC_LO65 = -ACC_HI65 - 65'sd1;

   function automatic logic [WORD_W-1:0] mag64(input logic signed [WORD_W-1:0] a);
      return a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
   endfunction

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   logic signed [DATA_W:0]    e_ff, e_in;
   logic signed [DATA_W:0]    ed_ff, ed_in;
   logic        [STEP_W-1:0]  dt_ff, dt_in;
   logic signed [ACC_WIDTH-1:0] integ_ff, integ_in;
   logic signed [WORD_W-1:0]  p_ff, p_in;
   logic signed [WORD_W-1:0]  d_ff, d_in;
   logic signed [WORD_W-1:0]  u_ff, u_in;
   logic signed [WORD_W-1:0]  iterm_ff, iterm_in;
   logic signed [WORD_W-1:0]  ui_ff, ui_in;
   logic signed [WORD_W-1:0]  diff_ff, diff_in;
   logic signed [DATA_W-1:0]  usat_ff, usat_in;
   logic                      sat_ff, sat_in;
   logic signed [DATA_W-1:0]  it_ff, it_in;

   logic signed [WORD_W-1:0] integ64, usat64, out_min64, out_max64;
   logic signed [WORD_W:0]   acc_sum, ui_sum;
   logic [DATA_W:0]          e_mag, ed_mag;
   logic [DATA_W-1:0]        pg_mag, dg_mag;
   logic                     integrate, trim, mul_go, div_go;

   // Shared helper terms.
   always_comb begin
      integ64   = WORD_W'(integ_ff);
      e_mag     = e_ff[DATA_W] ? (DATA_W+1)'(-e_ff) : (DATA_W+1)'(e_ff);
      ed_mag    = ed_ff[DATA_W] ? (DATA_W+1)'(-ed_ff) : (DATA_W+1)'(ed_ff);
      pg_mag    = gains.prop_gain[DATA_W-1] ? DATA_W'(-gains.prop_gain)
                                            : DATA_W'(gains.prop_gain);
      dg_mag    = gains.deriv_gain[DATA_W-1] ? DATA_W'(-gains.deriv_gain)
                                             : DATA_W'(gains.deriv_gain);
      out_min64 = WORD_W'(gains.out_min);
      out_max64 = WORD_W'(gains.out_max);
      integrate = (dt_ff != '0) && (gains.integ_gain != '0);
      trim      = sat_ff && (gains.integ_gain != '0) && (mag64(iterm_ff) > mag64(diff_ff));
      mul_go    = !pend_ff && !mul_rsp.done;
      div_go    = !pend_ff && !div_rsp.done;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_accept) state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            if (mul_rsp.done) state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            if (mul_rsp.done) state_in = integrate ? ST_MUL_E : ST_SUM;
         end
         ST_MUL_E: begin
            if (mul_rsp.done) state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            if (mul_rsp.done) state_in = ST_SUM;
         end
         ST_SUM:     state_in = ST_SAT_ADD;
         ST_SAT_ADD: state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = trim ? ST_DIV : ST_MUL_T;
         end
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            if (mul_rsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (result_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Unit commands and handshake outputs.
   always_comb begin
      mul_cmd              = '0;
      div_cmd              = '0;
      item_ready           = 1'b0;
      result.valid         = 1'b0;
      result.drive         = usat_ff;
      result.integral_term = it_ff;
      result.saturated     = sat_ff;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
         end
         ST_MUL_P: begin
            mul_cmd.start  = mul_go;
            mul_cmd.neg    = gains.prop_gain[DATA_W-1] ^ e_ff[DATA_W];
            mul_cmd.wide   = MUL_WIDE_W'(e_mag);
            mul_cmd.narrow = pg_mag;
         end
         ST_MUL_D: begin
            mul_cmd.start  = mul_go;
            mul_cmd.neg    = gains.deriv_gain[DATA_W-1] ^ ed_ff[DATA_W];
            mul_cmd.wide   = MUL_WIDE_W'(ed_mag);
            mul_cmd.narrow = dg_mag;
         end
         ST_MUL_E: begin
            mul_cmd.start  = mul_go;
            mul_cmd.neg    = e_ff[DATA_W];
            mul_cmd.wide   = MUL_WIDE_W'(e_mag);
            mul_cmd.narrow = MUL_NARROW_W'(dt_ff);
         end
         ST_MUL_I, ST_MUL_T: begin
            mul_cmd.start  = mul_go;
            mul_cmd.neg    = integ64[WORD_W-1];
            mul_cmd.wide   = mag64(integ64);
            mul_cmd.narrow = MUL_NARROW_W'(gains.integ_gain);
         end
         ST_DIV: begin
            div_cmd.start   = div_go;
            div_cmd.neg     = diff_ff[WORD_W-1];
            div_cmd.mag     = mag64(diff_ff);
            div_cmd.divisor = gains.integ_gain;
         end
         ST_DONE: begin
            result.valid = 1'b1;
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   // Outstanding unit request.
   always_comb begin
      pend_in = pend_ff;
      if (mul_cmd.start || div_cmd.start) begin
         pend_in = 1'b1;
      end else if (mul_rsp.done || div_rsp.done) begin
         pend_in = 1'b0;
      end
   end

   // Saturating sums of the integrator update and of the controller output.
   always_comb begin
      acc_sum = (WORD_W+1)'(integ64) + (WORD_W+1)'(mul_rsp.value);
      ui_sum  = (WORD_W+1)'(u_ff) + (WORD_W+1)'(iterm_ff);
      if (ui_ff > out_max64) begin
         usat64 = out_max64;
      end else if (ui_ff < out_min64) begin
         usat64 = out_min64;
      end else begin
         usat64 = ui_ff;
      end
   end

   // Datapath register updates.
   always_comb begin
      e_in     = e_ff;
      ed_in    = ed_ff;
      dt_in    = dt_ff;
      integ_in = integ_ff;
      p_in     = p_ff;
      d_in     = d_ff;
      u_in     = u_ff;
      iterm_in = iterm_ff;
      ui_in    = ui_ff;
      diff_in  = diff_ff;
      usat_in  = usat_ff;
      sat_in   = sat_ff;
      it_in    = it_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_accept) begin
               e_in     = (DATA_W+1)'(item.setpoint) - (DATA_W+1)'(item.measured);
               ed_in    = (DATA_W+1)'(item.setpoint_rate) - (DATA_W+1)'(item.measured_rate);
               iterm_in = '0;
               // A stale step drops the integrator and integrates nothing.
               if (item.time_step > ONE_Q) begin
                  dt_in    = '0;
                  integ_in = '0;
               end else begin
                  dt_in = item.time_step;
               end
            end
         end
         ST_MUL_P: begin
            if (mul_rsp.done) p_in = mul_rsp.value;
         end
         ST_MUL_D: begin
            if (mul_rsp.done) d_in = mul_rsp.value;
         end
         ST_MUL_E: begin
            if (mul_rsp.done) begin
               if (acc_sum > ACC_HI65) begin
                  integ_in = ACC_WIDTH'(ACC_HI65);
               end else if (acc_sum < ACC_LO65) begin
                  integ_in = ACC_WIDTH'(ACC_LO65);
               end else begin
                  integ_in = ACC_WIDTH'(acc_sum);
               end
            end
         end
         ST_MUL_I: begin
            if (mul_rsp.done) iterm_in = mul_rsp.value;
         end
         ST_SUM: begin
            u_in = p_ff + d_ff;
         end
         ST_SAT_ADD: begin
            if (ui_sum[WORD_W] != ui_sum[WORD_W-1]) begin
               ui_in = ui_sum[WORD_W] ? 64'sh8000_0000_0000_0000
                                      : 64'sh7FFF_FFFF_FFFF_FFFF;
            end else begin
               ui_in = ui_sum[WORD_W-1:0];
            end
         end
         ST_CLAMP: begin
            usat_in = usat64[DATA_W-1:0];
            sat_in  = (usat64 != ui_ff);
         end
         ST_DIFF: begin
            diff_in = WORD_W'(usat_ff) - u_ff;
         end
         ST_DIV: begin
            if (div_rsp.done) integ_in = ACC_WIDTH'(div_rsp.value);
         end
         ST_MUL_T: begin
            if (mul_rsp.done) begin
               if (mul_rsp.value[WORD_W-1:DATA_W-1] ==
                   {(WORD_W-DATA_W+1){mul_rsp.value[WORD_W-1]}}) begin
                  it_in = mul_rsp.value[DATA_W-1:0];
               end else begin
                  it_in = mul_rsp.value[WORD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end
            end
         end
         default: begin
            it_in = it_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      ed_ff    <= ed_in;
      dt_ff    <= dt_in;
      p_ff     <= p_in;
      d_ff     <= d_in;
      u_ff     <= u_in;
      iterm_ff <= iterm_in;
      ui_ff    <= ui_in;
      diff_ff  <= diff_in;
      usat_ff  <= usat_in;
      sat_ff   <= sat_in;
      it_ff    <= it_in;
   end

   // A unit only reports back on a request this sequencer made.
   assert property (@(posedge clock) disable iff (reset) mul_rsp.done |-> pend_ff)
      else $error("multiplier finished without a pending request");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the trim state");

   // No unit is busy for this sequencer once it is ready for a new beat.
   assert property (@(posedge clock) disable iff (reset) item_ready |-> !pend_ff)
      else $error("ready for a new beat with a unit request outstanding");

endmodule

>>> sv/pid_tracking_antiwindup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID tracking controller with anti-windup clamping
// Channel | Direction | Handshake                | Payload
// req     | in        | req_tvalid / req_tready  | req_tdata: time_step, setpoint,
//         |           |                          |   setpoint_rate, measured, measured_rate
// rsp     | out       | rsp_tvalid / rsp_tready  | rsp_tdata: drive, integral_term;
//         |           |                          |   rsp_tuser: saturated
// csr     | in        | csr_valid / csr_ready    | csr_index, csr_data
//
// A beat runs the proportional and derivative products, the integrator products
// when the integrator runs, and a trim division when the integrator is trimmed,
// on the shared byte-serial multiplier and the two-bit per cycle divider. The
// sequencer passes through idle between beats.
// Reset is synchronous and clears the gains, limits and integrator to zero.
// A stalled result waits in the output register while the next beat runs.
// ----------------------------------------------------------------------------
module pid_tracking_antiwindup
   import pta_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ACC_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, from bit 0: time_step[30:0], setpoint[62:31],
   // setpoint_rate[94:63], measured[126:95], measured_rate[158:127], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [159:0]           req_tdata,
   // rsp_tdata, from bit 0: drive[31:0], integral_term[63:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   // rsp_tuser, from bit 0: saturated
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   gains_type   gains_ff, gains_in;
   item_type    item;
   result_type  result;
   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic        item_ready, req_beat, rsp_load;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tuser_ff, rsp_tuser_in;

   // Register file writes; unknown indexes are dropped.
   always_comb begin
      gains_in = gains_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:  gains_in.prop_gain  = csr_data;
            CSR_INTEG_GAIN: gains_in.integ_gain = csr_data[STEP_W-1:0];
            CSR_DERIV_GAIN: gains_in.deriv_gain = csr_data;
            CSR_OUT_MIN:    gains_in.out_min    = csr_data;
            CSR_OUT_MAX:    gains_in.out_max    = csr_data;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Unpack the request beat.
   always_comb begin
      item.time_step     = req_tdata[30:0];
      item.setpoint      = req_tdata[62:31];
      item.setpoint_rate = req_tdata[94:63];
      item.measured      = req_tdata[126:95];
      item.measured_rate = req_tdata[158:127];
   end

   assign req_tready = item_ready;
   assign req_beat   = req_tvalid && req_tready;

   pta_ctrl #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_beat),
      .item        (item),
      .gains       (gains_ff),
      .item_ready  (item_ready),
      .result      (result),
      .result_take (rsp_load),
      .mul_cmd     (mul_cmd),
      .mul_rsp     (mul_rsp),
      .div_cmd     (div_cmd),
      .div_rsp     (div_rsp)
   );

   pta_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   pta_div #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Output register: loads a finished step whenever it is empty or draining.
   always_comb begin
      rsp_load      = result.valid && (!rsp_tvalid_ff || rsp_tready);
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {result.integral_term, result.drive};
         rsp_tuser_in  = result.saturated;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         gains_ff      <= gains_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A step holds the sequencer out of idle, so the input closes right after a beat.
   assert property (@(posedge clock) disable iff (reset) req_beat |=> !req_tready)
      else $error("request accepted on consecutive cycles");

   // A clamped output sits on one of the two limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[31:0] == gains_ff.out_max) || (rsp_tdata[31:0] == gains_ff.out_min))
      else $error("saturated output off both limits");

   // A finished step is only taken into an output register that is free or draining.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the PID tracking controller with anti-windup clamping
// A table of directed beats runs first. Random gain settings and random beats
// follow, with bursty input traffic and a receiver that stalls at random.
// Every result beat is compared field by field against a fixed table value or
// a fixed-point controller model with its own copy of the gains and integrator.
// ----------------------------------------------------------------------------
module tb
   import pta_pkg::*;
();

   // Fixed-point format of the controller.
   localparam int FRAC = 16;
   localparam int ACC_W = 48;
   localparam logic signed [63:0] I64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] I64_LO = 64'sh8000_0000_0000_0000;
   localparam logic signed [127:0] W_HI = I64_HI;
   localparam logic signed [127:0] W_LO = I64_LO;
   localparam logic signed [63:0] ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
   localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;
   localparam logic [127:0] ACC_SPAN = 128'd1 << (ACC_W - 1);
   localparam logic signed [63:0] I32_HI = 64'sd2147483647;
   localparam logic signed [63:0] I32_LO = -64'sd2147483648;
   localparam logic [STEP_W-1:0] ONE_SECOND = 31'h0001_0000;

   // Register indexes that decode to nothing.
   localparam logic [CSR_INDEX_W-1:0] BAD_INDEX_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] BAD_INDEX_HI = 3'd7;

   localparam int RANDOM_BEATS = 1650;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic signed [DATA_W-1:0] integral_term;
      logic                     saturated;
   } control_out_type;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_BEAT,
      ROW_BEAT_FIXED
   } row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [DATA_W-1:0]        value;
      item_type                 beat;
      control_out_type          want;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [159:0]           req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [63:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_data;

   // Model state: shadow gains and the integrator.
   gains_type          gain_set;
   logic signed [63:0] acc_state;

   control_out_type pending_outputs[$];
   control_out_type want_now;
   row_type         directed[$];
   logic            hold_request;

   int errors;
   int beats_sent;
   int results_seen;
   int reg_writes;
   int clamp_count;
   int trim_count;
   int stale_count;

   pid_tracking_antiwindup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Q16.16 product, floored, saturated to 64 bits.
   function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [127:0] wa, wb, prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> FRAC;
      if (prod > W_HI) return I64_HI;
      if (prod < W_LO) return I64_LO;
      return prod[63:0];
   endfunction

   // Sum clamped to [lo, hi].
   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
      logic signed [65:0] wa, wb, s;
      wa = a;
      wb = b;
      s = wa + wb;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s[63:0];
   endfunction

   // One controller step; updates the shadow integrator.
   function automatic control_out_type compute_control(input item_type beat);
      logic [STEP_W-1:0]  dt;
      logic signed [63:0] sp, spr, ms, msr, e, ed, kp, ki, kd, lo_lim, hi_lim;
      logic signed [63:0] p, d, u, ui, i_term, usat, diff, it_full;
      logic [63:0]        diff_mag, i_mag;
      logic [127:0]       quot;
      control_out_type    res;
      dt = beat.time_step;
      sp = $signed(beat.setpoint);
      spr = $signed(beat.setpoint_rate);
      ms = $signed(beat.measured);
      msr = $signed(beat.measured_rate);
      e = sp - ms;
      ed = spr - msr;
      kp = $signed(gain_set.prop_gain);
      kd = $signed(gain_set.deriv_gain);
      ki = {33'd0, gain_set.integ_gain};
      hi_lim = $signed(gain_set.out_max);
      lo_lim = $signed(gain_set.out_min);

      // A step longer than one second restarts the integrator.
      if (dt > ONE_SECOND) begin
         acc_state = 64'sd0;
         dt = '0;
         stale_count++;
      end

      p = fix_mul(kp, e);
      d = fix_mul(kd, ed);
      i_term = 64'sd0;
      if (dt != 0 && ki != 0) begin
         acc_state = sat_sum(acc_state, fix_mul(e, {33'd0, dt}), ACC_LO, ACC_HI);
         i_term = fix_mul(ki, acc_state);
      end

      // The upper limit is tested first, so reversed limits favor out_max.
      u = p + d;
      ui = sat_sum(u, i_term, I64_LO, I64_HI);
      if (ui > hi_lim) begin
         usat = hi_lim;
      end else if (ui < lo_lim) begin
         usat = lo_lim;
      end else begin
         usat = ui;
      end
      res.saturated = (ui != usat);

      // Back-calculate the integrator when it drove the output into a limit.
      diff = usat - u;
      diff_mag = diff[63] ? -diff : diff;
      i_mag = i_term[63] ? -i_term : i_term;
      if (res.saturated && ki != 0 && i_mag > diff_mag) begin
         quot = {64'd0, diff_mag} << FRAC;
         quot = quot / {97'd0, gain_set.integ_gain};
         if (diff[63]) begin
            acc_state = (quot > ACC_SPAN) ? ACC_LO : -$signed(quot[63:0]);
         end else begin
            acc_state = (quot >= ACC_SPAN) ? ACC_HI : $signed(quot[63:0]);
         end
         trim_count++;
      end

      it_full = fix_mul(ki, acc_state);
      if (it_full > I32_HI) begin
         res.integral_term = I32_HI[31:0];
      end else if (it_full < I32_LO) begin
         res.integral_term = I32_LO[31:0];
      end else begin
         res.integral_term = it_full[31:0];
      end
      res.drive = usat[31:0];
      if (res.saturated) clamp_count++;
      return res;
   endfunction

   // Uniform value in +/- 2^(bits-1) LSBs.
   function automatic logic [DATA_W-1:0] small_q(input int bits);
      small_q = $urandom_range(0, (32'd1 << bits) - 1) - (32'd1 << (bits - 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: pick_extreme = 32'h7FFF_FFFF;
         1: pick_extreme = 32'h8000_0000;
         2: pick_extreme = 32'h0000_0000;
         3: pick_extreme = 32'hFFFF_FFFF;
         4: pick_extreme = 32'h0000_0001;
         default: pick_extreme = 32'h0001_0000;
      endcase
   endfunction

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      row_type row;
      row.kind = ROW_CSR;
      row.index = idx;
      row.value = value;
      row.beat = '0;
      row.want = '0;
      directed.push_back(row);
   endtask

   task automatic add_beat(input row_kind_type kind, input logic [STEP_W-1:0] dt,
                           input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] spr,
                           input logic [DATA_W-1:0] ms, input logic [DATA_W-1:0] msr,
                           input logic [DATA_W-1:0] drv, input logic [DATA_W-1:0] integ,
                           input logic sat);
      row_type row;
      row.kind = kind;
      row.index = '0;
      row.value = '0;
      row.beat.time_step = dt;
      row.beat.setpoint = sp;
      row.beat.setpoint_rate = spr;
      row.beat.measured = ms;
      row.beat.measured_rate = msr;
      row.want.drive = drv;
      row.want.integral_term = integ;
      row.want.saturated = sat;
      directed.push_back(row);
   endtask

   // Stop offering beats and wait until every expected result has come.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // Register write; only called while the controller is idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PROP_GAIN:  gain_set.prop_gain = value;
         CSR_INTEG_GAIN: gain_set.integ_gain = value[STEP_W-1:0];
         CSR_DERIV_GAIN: gain_set.deriv_gain = value;
         CSR_OUT_MIN:    gain_set.out_min = value;
         CSR_OUT_MAX:    gain_set.out_max = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one input beat and record its expected result once accepted.
   // tvalid stays high on return so that a following beat goes back to back.
   task automatic send_beat(input item_type beat, input logic use_fixed,
                            input control_out_type fixed);
      control_out_type predicted;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {1'b0, beat.measured_rate, beat.measured, beat.setpoint_rate,
                   beat.setpoint, beat.time_step};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = compute_control(beat);
      pending_outputs.push_back(use_fixed ? fixed : predicted);
      beats_sent++;
   endtask

   // Receiver: random stall patterns, plus one long hold on request.
   initial begin : receiver
      int ready_mode;
      int mode_left;
      int hold_left;
      bit hold_used;
      rsp_tready = 1'b0;
      ready_mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_used = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request && !hold_used) begin
            hold_left = LONG_HOLD;
            hold_used = 1'b1;
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            $error("result beat arrived with nothing expected");
            errors++;
         end else begin
            want_now = pending_outputs.pop_front();
            results_seen++;
            if (rsp_tdata[31:0] !== want_now.drive) begin
               $error("drive: expected %h, got %h", want_now.drive, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want_now.integral_term) begin
               $error("integral_term: expected %h, got %h", want_now.integral_term,
                      rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser !== want_now.saturated) begin
               $error("saturated: expected %b, got %b", want_now.saturated, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      item_type          beat;
      logic [DATA_W-1:0] kp, ki, kd, mn, mx, lim;
      int                phase;
      int                random_beats;
      int                n_beats;
      int                sent;
      int                burst;
      int                gap;
      int                k;
      bit                quiet;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_request = 1'b0;
      gain_set = '0;
      acc_state = 64'sd0;
      errors = 0;
      beats_sent = 0;
      results_seen = 0;
      reg_writes = 0;
      clamp_count = 0;
      trim_count = 0;
      stale_count = 0;

      // Directed table. After reset all gains and limits are zero.
      add_beat(ROW_BEAT_FIXED, 31'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h0, 32'h0, 1'b0);
      add_beat(ROW_BEAT_FIXED, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
      // Writes to undecoded indexes must leave every register alone.
      add_csr(BAD_INDEX_LO, 32'hFFFF_FFFF);
      add_csr(BAD_INDEX_HI, 32'hFFFF_FFFF);
      add_beat(ROW_BEAT_FIXED, ONE_SECOND, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 1'b0);
      // Unit proportional and integral gains, derivative gain 0.5, limits of +/- 16.0.
      add_csr(CSR_PROP_GAIN, 32'h0001_0000);
      add_csr(CSR_INTEG_GAIN, 32'h0001_0000);
      add_csr(CSR_DERIV_GAIN, 32'h0000_8000);
      add_csr(CSR_OUT_MIN, 32'hFFF0_0000);
      add_csr(CSR_OUT_MAX, 32'h0010_0000);
      add_beat(ROW_BEAT, 31'h8000, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0000_8000,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, 31'h0, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0000_8000,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND + 31'd1, 32'h0005_0000, 32'h0, 32'h0, 32'h0,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0,
               '0, '0, 1'b0);
      add_beat(ROW_BEAT, 31'h1, 32'h0, 32'h0, 32'h0, 32'h0, '0, '0, 1'b0);
      // Reversed limits.
      add_csr(CSR_OUT_MIN, 32'h0010_0000);
      add_csr(CSR_OUT_MAX, 32'hFFF0_0000);
      add_beat(ROW_BEAT, 31'h4000, 32'h0, 32'h0, 32'h0, 32'h0, '0, '0, 1'b0);
      add_beat(ROW_BEAT, 31'h4000, 32'h8000_0000, 32'h0, 32'h0, 32'h0, '0, '0, 1'b0);
      // Extreme gains; bit 31 of the integral gain must be dropped.
      add_csr(CSR_PROP_GAIN, 32'h7FFF_FFFF);
      add_csr(CSR_INTEG_GAIN, 32'hFFFF_FFFF);
      add_csr(CSR_DERIV_GAIN, 32'h8000_0000);
      add_csr(CSR_OUT_MIN, 32'h8000_0000);
      add_csr(CSR_OUT_MAX, 32'h7FFF_FFFF);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, '0, '0, 1'b0);
      add_beat(ROW_BEAT, ONE_SECOND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, '0, '0, 1'b0);
      add_beat(ROW_BEAT, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, '0, '0, 1'b0);
      // Integration off, both limits at zero: any nonzero sum clamps to zero.
      add_csr(CSR_INTEG_GAIN, 32'h0);
      add_csr(CSR_PROP_GAIN, 32'h0002_0000);
      add_csr(CSR_DERIV_GAIN, 32'h0);
      add_csr(CSR_OUT_MIN, 32'h0);
      add_csr(CSR_OUT_MAX, 32'h0);
      add_beat(ROW_BEAT_FIXED, 31'h8000, 32'h0004_0000, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 1'b1);
      add_beat(ROW_BEAT_FIXED, 31'h8000, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 1'b1);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[n]) begin
         if (directed[n].kind == ROW_CSR) begin
            drain();
            write_reg(directed[n].index, directed[n].value);
         end else begin
            send_beat(directed[n].beat, directed[n].kind == ROW_BEAT_FIXED, directed[n].want);
         end
      end

      // Random phases, each with its own gain setting.
      phase = 0;
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         drain();
         case (phase % 4)
            0: begin
               kp = $urandom_range(0, 32'h0008_0000);
               ki = $urandom_range(0, 32'h0004_0000);
               kd = small_q(18);
               lim = $urandom_range(32'h0001_0000, 32'h0040_0000);
               mx = lim;
               mn = -lim;
            end
            1: begin
               kp = $urandom();
               ki = $urandom();
               kd = $urandom();
               mn = $urandom();
               mx = $urandom();
               write_reg(BAD_INDEX_LO + CSR_INDEX_W'($urandom_range(0, 2)), $urandom());
            end
            2: begin
               kp = pick_extreme();
               ki = pick_extreme();
               kd = pick_extreme();
               mn = pick_extreme();
               mx = pick_extreme();
            end
            default: begin
               kp = $urandom_range(0, 32'h0008_0000);
               ki = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom_range(1, 32'h0004_0000);
               kd = small_q(18);
               lim = $urandom_range(32'h0001_0000, 32'h0040_0000);
               if ($urandom_range(0, 1)) begin
                  mx = -lim;
                  mn = lim;
               end else begin
                  mx = lim;
                  mn = -lim;
               end
            end
         endcase
         write_reg(CSR_PROP_GAIN, kp);
         write_reg(CSR_INTEG_GAIN, ki);
         write_reg(CSR_DERIV_GAIN, kd);
         write_reg(CSR_OUT_MIN, mn);
         write_reg(CSR_OUT_MAX, mx);

         n_beats = $urandom_range(80, 160);
         quiet = (phase % 3 == 2);
         sent = 0;
         while (sent < n_beats) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < n_beats; k++) begin
               // Time step: mostly short, with zero, exactly one second and stale.
               case ($urandom_range(0, 15))
                  0: beat.time_step = '0;
                  1: beat.time_step = ONE_SECOND;
                  2: beat.time_step = ONE_SECOND + 31'd1;
                  3: beat.time_step = STEP_W'($urandom());
                  4: beat.time_step = 31'h7FFF_FFFF;
                  5, 6: beat.time_step = STEP_W'($urandom_range(1, ONE_SECOND));
                  default: beat.time_step = STEP_W'($urandom_range(1, 31'h1000));
               endcase
               // Signals: mostly a measurement that tracks the setpoint.
               case ($urandom_range(0, 9))
                  0: begin
                     beat.setpoint = $urandom();
                     beat.setpoint_rate = $urandom();
                     beat.measured = $urandom();
                     beat.measured_rate = $urandom();
                  end
                  1: begin
                     beat.setpoint = pick_extreme();
                     beat.setpoint_rate = pick_extreme();
                     beat.measured = pick_extreme();
                     beat.measured_rate = pick_extreme();
                  end
                  default: begin
                     beat.setpoint = small_q(23);
                     beat.measured = beat.setpoint + small_q(19);
                     beat.setpoint_rate = small_q(20);
                     beat.measured_rate = beat.setpoint_rate + small_q(17);
                  end
               endcase
               send_beat(beat, 1'b0, '0);
               sent++;
               // Let the result path back up into the input.
               if (phase == 1 && sent == 20) hold_request = 1'b1;
               // Let the pipeline run dry in the middle of a phase.
               if (phase == 5 && sent == n_beats / 2) drain();
            end
            if (!quiet) begin
               gap = $urandom_range(0, 8);
               if (gap > 0) begin
                  @(negedge clock);
                  req_tvalid = 1'b0;
                  repeat (gap - 1) @(negedge clock);
               end
            end
         end
         random_beats += n_beats;
         phase++;
      end

      drain();
      repeat (100) @(posedge clock);
      $display("summary: %0d input beats, %0d register writes, %0d results compared",
               beats_sent, reg_writes, results_seen);
      $display("summary: %0d clamped outputs, %0d integrator trims, %0d stale steps",
               clamp_count, trim_count, stale_count);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/pta_pkg.sv
sv/pta_mul.sv
sv/pta_div.sv
sv/pta_ctrl.sv
sv/pid_tracking_antiwindup.sv
tb/sv/tb.sv
